/* design/cpu8_pkg.sv */
// Shared types, operation codes and reset constants for the 8-bit execute unit.
package cpu8_pkg;

  localparam int unsigned DataWidth = 8;
  localparam int unsigned CmdWidth  = 6;
  localparam int unsigned CondWidth = 3;

  // Status register bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagU = 5;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [DataWidth-1:0] SpReset     = 8'hFD;
  localparam logic [DataWidth-1:0] StatusReset = 8'h24;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADC = 6'd0,  CMD_SBC = 6'd1,  CMD_AND = 6'd2,  CMD_ORA = 6'd3,
    CMD_EOR = 6'd4,  CMD_ASL = 6'd5,  CMD_LSR = 6'd6,  CMD_ROL = 6'd7,
    CMD_ROR = 6'd8,  CMD_INC = 6'd9,  CMD_DEC = 6'd10, CMD_CMP = 6'd11,
    CMD_CPX = 6'd12, CMD_CPY = 6'd13, CMD_BIT = 6'd14, CMD_LDA = 6'd15,
    CMD_LDX = 6'd16, CMD_LDY = 6'd17, CMD_TAX = 6'd18, CMD_TAY = 6'd19,
    CMD_TSX = 6'd20, CMD_TXA = 6'd21, CMD_TXS = 6'd22, CMD_TYA = 6'd23,
    CMD_INX = 6'd24, CMD_INY = 6'd25, CMD_DEX = 6'd26, CMD_DEY = 6'd27,
    CMD_SEC = 6'd28, CMD_CLC = 6'd29, CMD_SEI = 6'd30, CMD_CLI = 6'd31,
    CMD_SED = 6'd32, CMD_CLD = 6'd33, CMD_CLV = 6'd34, CMD_STA = 6'd35,
    CMD_STX = 6'd36, CMD_STY = 6'd37, CMD_BRANCH = 6'd38, CMD_NOP = 6'd39
  } cmd_t;

  typedef enum logic [CondWidth-1:0] {
    COND_CC = 3'd0, COND_CS = 3'd1, COND_EQ = 3'd2, COND_MI = 3'd3,
    COND_NE = 3'd4, COND_PL = 3'd5, COND_VC = 3'd6, COND_VS = 3'd7
  } cond_t;

  typedef struct packed {
    logic [CmdWidth-1:0]  cmd;
    logic [DataWidth-1:0] operand;
    logic                 on_accumulator;
    logic [CondWidth-1:0] branch_cond;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] write_data;
    logic                 write_enable;
    logic                 branch_taken;
    logic [DataWidth-1:0] status_out;
  } out_item_t;

  // Architectural registers
  typedef struct packed {
    logic [DataWidth-1:0] acc;
    logic [DataWidth-1:0] x;
    logic [DataWidth-1:0] y;
    logic [DataWidth-1:0] sp;
    logic [DataWidth-1:0] status;
  } arch_t;

endpackage

/* design/cpu8_alu.sv */
// Combinational execute logic: one operation against the current registers.
module cpu8_alu (
  input  cpu8_pkg::in_item_t  item,
  input  cpu8_pkg::arch_t     cur,
  output cpu8_pkg::arch_t     nxt,
  output cpu8_pkg::out_item_t res
);

  logic [cpu8_pkg::DataWidth-1:0] p;
  logic [cpu8_pkg::DataWidth-1:0] addend;
  logic [cpu8_pkg::DataWidth:0]   sum;
  logic [cpu8_pkg::DataWidth-1:0] cmp_reg;
  logic [cpu8_pkg::DataWidth:0]   diff;
  logic [cpu8_pkg::DataWidth-1:0] sh_in;
  logic [cpu8_pkg::DataWidth-1:0] sh_out;
  logic                           sh_carry;
  logic [cpu8_pkg::DataWidth-1:0] nz_val;
  logic                           nz_upd;
  logic                           taken;
  cpu8_pkg::cmd_t                 op;

  function automatic logic [cpu8_pkg::DataWidth-1:0] put_nz(
    input logic [cpu8_pkg::DataWidth-1:0] st,
    input logic [cpu8_pkg::DataWidth-1:0] v
  );
    logic [cpu8_pkg::DataWidth-1:0] r;
    r = st;
    r[cpu8_pkg::FlagN] = v[cpu8_pkg::DataWidth-1];
    r[cpu8_pkg::FlagZ] = (v == '0);
    return r;
  endfunction

  assign op = cpu8_pkg::cmd_t'(item.cmd);

  // Shared adder for ADC and SBC (SBC adds the inverted operand)
  assign addend = (op == cpu8_pkg::CMD_SBC) ? ~item.operand : item.operand;
  assign sum    = {1'b0, cur.acc} + {1'b0, addend}
                + {{cpu8_pkg::DataWidth{1'b0}}, cur.status[cpu8_pkg::FlagC]};

  // Shared subtractor for the three compares
  always_comb begin
    case (op)
      cpu8_pkg::CMD_CPX: cmp_reg = cur.x;
      cpu8_pkg::CMD_CPY: cmp_reg = cur.y;
      default:           cmp_reg = cur.acc;
    endcase
  end
  assign diff = {1'b0, cmp_reg} - {1'b0, item.operand};

  // Shifter for ASL / LSR / ROL / ROR
  assign sh_in = item.on_accumulator ? cur.acc : item.operand;
  always_comb begin
    if (op == cpu8_pkg::CMD_ASL || op == cpu8_pkg::CMD_ROL) begin
      sh_carry = sh_in[cpu8_pkg::DataWidth-1];
      sh_out   = {sh_in[cpu8_pkg::DataWidth-2:0],
                  (op == cpu8_pkg::CMD_ROL) & cur.status[cpu8_pkg::FlagC]};
    end else begin
      sh_carry = sh_in[0];
      sh_out   = {(op == cpu8_pkg::CMD_ROR) & cur.status[cpu8_pkg::FlagC],
                  sh_in[cpu8_pkg::DataWidth-1:1]};
    end
  end

  always_comb begin
    case (cpu8_pkg::cond_t'(item.branch_cond))
      cpu8_pkg::COND_CC: taken = !cur.status[cpu8_pkg::FlagC];
      cpu8_pkg::COND_CS: taken =  cur.status[cpu8_pkg::FlagC];
      cpu8_pkg::COND_EQ: taken =  cur.status[cpu8_pkg::FlagZ];
      cpu8_pkg::COND_MI: taken =  cur.status[cpu8_pkg::FlagN];
      cpu8_pkg::COND_NE: taken = !cur.status[cpu8_pkg::FlagZ];
      cpu8_pkg::COND_PL: taken = !cur.status[cpu8_pkg::FlagN];
      cpu8_pkg::COND_VC: taken = !cur.status[cpu8_pkg::FlagV];
      default:           taken =  cur.status[cpu8_pkg::FlagV];
    endcase
  end

  always_comb begin
    nxt    = cur;
    res    = '0;
    p      = cur.status;
    nz_val = '0;
    nz_upd = 1'b0;
    case (op)
      cpu8_pkg::CMD_ADC, cpu8_pkg::CMD_SBC: begin
        p[cpu8_pkg::FlagC] = sum[cpu8_pkg::DataWidth];
        p[cpu8_pkg::FlagV] = ~(cur.acc[7] ^ addend[7]) & (cur.acc[7] ^ sum[7]);
        nxt.acc = sum[cpu8_pkg::DataWidth-1:0];
        nz_val  = sum[cpu8_pkg::DataWidth-1:0];
        nz_upd  = 1'b1;
      end
      cpu8_pkg::CMD_AND: begin
        nxt.acc = cur.acc & item.operand; nz_val = nxt.acc; nz_upd = 1'b1;
      end
      cpu8_pkg::CMD_ORA: begin
        nxt.acc = cur.acc | item.operand; nz_val = nxt.acc; nz_upd = 1'b1;
      end
      cpu8_pkg::CMD_EOR: begin
        nxt.acc = cur.acc ^ item.operand; nz_val = nxt.acc; nz_upd = 1'b1;
      end
      cpu8_pkg::CMD_ASL, cpu8_pkg::CMD_LSR, cpu8_pkg::CMD_ROL, cpu8_pkg::CMD_ROR: begin
        p[cpu8_pkg::FlagC] = sh_carry;
        nz_val = sh_out;
        nz_upd = 1'b1;
        if (item.on_accumulator) begin
          nxt.acc = sh_out;
        end else begin
          res.write_data   = sh_out;
          res.write_enable = 1'b1;
        end
      end
      cpu8_pkg::CMD_INC: begin
        res.write_data   = item.operand + 8'd1;
        res.write_enable = 1'b1;
        nz_val = res.write_data; nz_upd = 1'b1;
      end
      cpu8_pkg::CMD_DEC: begin
        res.write_data   = item.operand - 8'd1;
        res.write_enable = 1'b1;
        nz_val = res.write_data; nz_upd = 1'b1;
      end
      cpu8_pkg::CMD_CMP, cpu8_pkg::CMD_CPX, cpu8_pkg::CMD_CPY: begin
        p[cpu8_pkg::FlagC] = !diff[cpu8_pkg::DataWidth];
        nz_val = diff[cpu8_pkg::DataWidth-1:0]; nz_upd = 1'b1;
      end
      cpu8_pkg::CMD_BIT: begin
        p[cpu8_pkg::FlagN] = item.operand[7];
        p[cpu8_pkg::FlagV] = item.operand[6];
        p[cpu8_pkg::FlagZ] = ((item.operand & cur.acc) == '0);
      end
      cpu8_pkg::CMD_LDA: begin nxt.acc = item.operand; nz_val = item.operand; nz_upd = 1'b1; end
      cpu8_pkg::CMD_LDX: begin nxt.x = item.operand; nz_val = item.operand; nz_upd = 1'b1; end
      cpu8_pkg::CMD_LDY: begin nxt.y = item.operand; nz_val = item.operand; nz_upd = 1'b1; end
      cpu8_pkg::CMD_TAX: begin nxt.x = cur.acc; nz_val = cur.acc; nz_upd = 1'b1; end
      cpu8_pkg::CMD_TAY: begin nxt.y = cur.acc; nz_val = cur.acc; nz_upd = 1'b1; end
      cpu8_pkg::CMD_TSX: begin nxt.x = cur.sp; nz_val = cur.sp; nz_upd = 1'b1; end
      cpu8_pkg::CMD_TXA: begin nxt.acc = cur.x; nz_val = cur.x; nz_upd = 1'b1; end
      cpu8_pkg::CMD_TXS: nxt.sp = cur.x;
      cpu8_pkg::CMD_TYA: begin nxt.acc = cur.y; nz_val = cur.y; nz_upd = 1'b1; end
      cpu8_pkg::CMD_INX: begin nxt.x = cur.x + 8'd1; nz_val = nxt.x; nz_upd = 1'b1; end
      cpu8_pkg::CMD_INY: begin nxt.y = cur.y + 8'd1; nz_val = nxt.y; nz_upd = 1'b1; end
      cpu8_pkg::CMD_DEX: begin nxt.x = cur.x - 8'd1; nz_val = nxt.x; nz_upd = 1'b1; end
      cpu8_pkg::CMD_DEY: begin nxt.y = cur.y - 8'd1; nz_val = nxt.y; nz_upd = 1'b1; end
      cpu8_pkg::CMD_SEC: p[cpu8_pkg::FlagC] = 1'b1;
      cpu8_pkg::CMD_CLC: p[cpu8_pkg::FlagC] = 1'b0;
      cpu8_pkg::CMD_SEI: p[cpu8_pkg::FlagI] = 1'b1;
      cpu8_pkg::CMD_CLI: p[cpu8_pkg::FlagI] = 1'b0;
      cpu8_pkg::CMD_SED: p[cpu8_pkg::FlagD] = 1'b1;
      cpu8_pkg::CMD_CLD: p[cpu8_pkg::FlagD] = 1'b0;
      cpu8_pkg::CMD_CLV: p[cpu8_pkg::FlagV] = 1'b0;
      cpu8_pkg::CMD_STA: begin res.write_data = cur.acc; res.write_enable = 1'b1; end
      cpu8_pkg::CMD_STX: begin res.write_data = cur.x; res.write_enable = 1'b1; end
      cpu8_pkg::CMD_STY: begin res.write_data = cur.y; res.write_enable = 1'b1; end
      cpu8_pkg::CMD_BRANCH: res.branch_taken = taken;
      default: ;
    endcase
    if (nz_upd) begin
      p = put_nz(p, nz_val);
    end
    nxt.status     = p;
    res.status_out = p;
  end

endmodule

/* design/cpu8_regfile.sv */
// Architectural register file: A, X, Y, stack pointer and status.
module cpu8_regfile (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd_en,
  input  cpu8_pkg::arch_t arch_nxt,
  output cpu8_pkg::arch_t arch
);

  cpu8_pkg::arch_t arch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r.acc    <= '0;
      arch_r.x      <= '0;
      arch_r.y      <= '0;
      arch_r.sp     <= cpu8_pkg::SpReset;
      arch_r.status <= cpu8_pkg::StatusReset;
    end else if (upd_en) begin
      arch_r <= arch_nxt;
    end
  end

  assign arch = arch_r;

endmodule

/* design/cpu8_alu_register_execute_top.sv */
// Top level of the 8-bit execute unit: input register, execute logic, result register.
//
//  channel | ports                         | direction | payload
//  --------+-------------------------------+-----------+------------------------------
//  in      | in_valid, in_ready, in_data   | to unit   | cmd, operand, on_accumulator,
//          |                               |           | branch_cond
//  out     | out_valid, out_ready, out_data| from unit | write_data, write_enable,
//          |                               |           | branch_taken, status_out
//
// One transaction per clock sustained while out_ready stays high. A transaction is
// held in the input register and moves to the result register when the result
// register is free or draining, which then raises out_valid.
// Execution and the register file update happen in the same cycle, so the next
// transaction always sees the registers left by the one before it.
// Synchronous active-low reset clears both valid flags and loads A/X/Y = 0,
// SP = 0xFD, status = 0x24.
// A stall on out_ready holds the result register and the input register; the
// input side still takes one more transaction while the result waits.
module cpu8_alu_register_execute_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpu8_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cpu8_pkg::out_item_t out_data
);

  cpu8_pkg::in_item_t  in_r;
  logic                in_vld_r;
  cpu8_pkg::out_item_t out_r;
  logic                out_vld_r;

  cpu8_pkg::arch_t     arch;
  cpu8_pkg::arch_t     arch_nxt;
  cpu8_pkg::out_item_t res;
  logic                advance;

  // Execute the held transaction when the result register is free or draining
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Input register: load on acceptance, drop valid once executed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  cpu8_alu u_alu (
    .item (in_r),
    .cur  (arch),
    .nxt  (arch_nxt),
    .res  (res)
  );

  // Commit register state only when the transaction moves to the result side
  cpu8_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (advance),
    .arch_nxt (arch_nxt),
    .arch     (arch)
  );

  // Result register: advance on execute, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // B and U status bits are never touched by any operation
  a_status_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.status_out[cpu8_pkg::FlagU] &&
                   !out_r.status_out[cpu8_pkg::FlagB]))
    else $error("status B/U bits corrupted");

  // No write strobe means a zero data byte
  a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.write_enable) |-> (out_r.write_data == '0))
    else $error("write_data nonzero without write_enable");

  // Registers hold when nothing executes
  a_arch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !advance) |=> $stable(arch))
    else $error("register state changed without execute");

  // Stack pointer changes only through TXS
  a_sp_txs_only: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(advance && in_r.cmd == cpu8_pkg::CMD_TXS)) |=> $stable(arch.sp))
    else $error("stack pointer changed outside TXS");

  // Branch result only for a branch transaction
  a_branch_only: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_r.cmd != cpu8_pkg::CMD_BRANCH) |=> !out_r.branch_taken)
    else $error("branch_taken set for non-branch");

endmodule
